### rtl/core/skf_pkg.sv
// Shared constants, field widths and the sequencer control bundle for the
// scalar Kalman position filter. Used by every module under rtl/core.
package skf_pkg;

    // Fixed-point format of the gain and width of the stored variance.
    localparam int GAIN_FRAC_BITS = 16;
    localparam int VARIANCE_BITS  = 40;

    // Field widths of one fix and of one result.
    localparam int ACC_BITS       = 16;
    localparam int ELAPSED_BITS   = 32;
    localparam int LAT_BITS       = 31;
    localparam int LNG_BITS       = 32;
    localparam int ALT_BITS       = 31;
    localparam int VOUT_BITS      = 40;
    localparam int GAIN_OUT_BITS  = 16;

    // Internal datapath widths.
    localparam int SQ_BITS        = 2 * ACC_BITS;
    localparam int PROD_BITS      = ELAPSED_BITS + SQ_BITS;
    localparam int MS_PER_S       = 1000;
    localparam int DREM_BITS      = $clog2(MS_PER_S);
    localparam int GROWTH_BITS    = 55;
    localparam int SUM_BITS       = ((VARIANCE_BITS > GROWTH_BITS) ?
                                     VARIANCE_BITS : GROWTH_BITS) + 1;
    localparam int EST_BITS       = 32;
    localparam int RES_BITS       = EST_BITS + 1;
    localparam int CNT_BITS       = $clog2(PROD_BITS);

    // Configuration port and register map.
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_ACCURACY = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY        = CFG_INDEX_BITS'(1);
    localparam logic [CFG_DATA_BITS-1:0]  MIN_ACCURACY_RESET = CFG_DATA_BITS'(100);
    localparam logic [CFG_DATA_BITS-1:0]  DECAY_RESET        = CFG_DATA_BITS'(300);

    // Strobes from the sequencer to the serial units.
    typedef struct packed {
        logic load;
        logic sq_step;
        logic mul_step;
        logic div_step;
        logic first_fix;
        logic var_add;
        logic gain_prep;
        logic gain_step;
        logic upd_step;
        logic apply;
    } skf_ctrl_t;

endpackage

### rtl/core/skf_growth_unit.sv
// Bit-serial squares of accuracy and decay, the elapsed-time product and the
// divide by 1000 that give the variance growth. Depends on skf_pkg.
module skf_growth_unit
    import skf_pkg::*;
(
    input  logic                      aclk,
    input  skf_ctrl_t                 ctrl,
    input  logic [ACC_BITS-1:0]       acc_in,
    input  logic [ACC_BITS-1:0]       decay,
    input  logic [ELAPSED_BITS-1:0]   elapsed_in,
    output logic [SQ_BITS-1:0]        acc_sq,
    output logic [GROWTH_BITS-1:0]    growth
);

    logic [ACC_BITS-1:0]  acc_reg;
    logic [SQ_BITS-1:0]   asq_reg, asq_next;
    logic [SQ_BITS-1:0]   dsq_reg, dsq_next;
    logic [PROD_BITS-1:0] prod_reg, prod_next;
    logic [DREM_BITS-1:0] drem_reg, drem_next;
    logic [ACC_BITS:0]    asum;
    logic [ACC_BITS:0]    dsum;
    logic [SQ_BITS:0]     psum;
    logic [DREM_BITS:0]   dtrial;
    logic                 dge;

    // Shift-add steps: multiplier bits leave at the bottom, partial sums enter at the top.
    always_comb begin
        asum = {1'b0, asq_reg[SQ_BITS-1:ACC_BITS]} +
               (asq_reg[0] ? {1'b0, acc_reg} : '0);
        dsum = {1'b0, dsq_reg[SQ_BITS-1:ACC_BITS]} +
               (dsq_reg[0] ? {1'b0, decay} : '0);
        psum = {1'b0, prod_reg[PROD_BITS-1:ELAPSED_BITS]} +
               (prod_reg[0] ? {1'b0, dsq_reg} : '0);
        dtrial = {drem_reg, prod_reg[PROD_BITS-1]};
        dge    = (dtrial >= (DREM_BITS+1)'(MS_PER_S));
    end

    // Next values of the square, product and quotient registers.
    always_comb begin
        asq_next  = asq_reg;
        dsq_next  = dsq_reg;
        prod_next = prod_reg;
        drem_next = drem_reg;
        if (ctrl.load) begin
            asq_next  = SQ_BITS'(acc_in);
            dsq_next  = SQ_BITS'(decay);
            prod_next = PROD_BITS'(elapsed_in);
            drem_next = '0;
        end else if (ctrl.sq_step) begin
            asq_next = {asum, asq_reg[ACC_BITS-1:1]};
            dsq_next = {dsum, dsq_reg[ACC_BITS-1:1]};
        end else if (ctrl.mul_step) begin
            prod_next = {psum, prod_reg[ELAPSED_BITS-1:1]};
        end else if (ctrl.div_step) begin
            // Restoring long division by 1000, one quotient bit per cycle.
            drem_next = dge ? DREM_BITS'(dtrial - (DREM_BITS+1)'(MS_PER_S))
                            : dtrial[DREM_BITS-1:0];
            prod_next = {prod_reg[PROD_BITS-2:0], dge};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            acc_reg <= acc_in;
        end
        asq_reg  <= asq_next;
        dsq_reg  <= dsq_next;
        prod_reg <= prod_next;
        drem_reg <= drem_next;
    end

    assign acc_sq = asq_reg;
    assign growth = prod_reg[GROWTH_BITS-1:0];

endmodule

### rtl/core/skf_var_gain.sv
// Variance register, bit-serial gain divider and serial variance decrement.
// Depends on skf_pkg.
module skf_var_gain
    import skf_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  skf_ctrl_t                   ctrl,
    input  logic [SQ_BITS-1:0]          acc_sq,
    input  logic [GROWTH_BITS-1:0]      growth,
    output logic [VARIANCE_BITS-1:0]    var_out,
    output logic [GAIN_FRAC_BITS-1:0]   gain,
    output logic                        k_bit
);

    localparam logic [VARIANCE_BITS-1:0] VAR_MAX = {VARIANCE_BITS{1'b1}};

    logic [VARIANCE_BITS-1:0]  var_reg, var_next;
    logic [GAIN_FRAC_BITS-1:0] k_reg, k_next;
    logic [VARIANCE_BITS:0]    den_reg, den_next;
    logic [VARIANCE_BITS:0]    rem_reg, rem_next;
    logic                      den_zero_reg, den_zero_next;
    logic [VARIANCE_BITS-1:0]  dec_reg, dec_next;
    logic [SUM_BITS-1:0]       vsum;
    logic [VARIANCE_BITS+1:0]  rem2;
    logic                      qbit;
    logic [VARIANCE_BITS:0]    dsum;

    // Saturating growth sum, trial subtraction and decrement partial sum.
    always_comb begin
        vsum = SUM_BITS'(var_reg) + SUM_BITS'(growth);
        rem2 = {rem_reg, 1'b0};
        qbit = (rem2 >= (VARIANCE_BITS+2)'(den_reg)) && !den_zero_reg;
        dsum = (VARIANCE_BITS+1)'(dec_reg) +
               (k_reg[0] ? (VARIANCE_BITS+1)'(var_reg) : '0);
    end

    always_comb begin
        var_next      = var_reg;
        k_next        = k_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        den_zero_next = den_zero_reg;
        dec_next      = dec_reg;
        if (ctrl.load) begin
            k_next = '0;
        end
        if (ctrl.first_fix) begin
            var_next = VARIANCE_BITS'(acc_sq);
        end
        if (ctrl.var_add) begin
            var_next = (vsum > SUM_BITS'(VAR_MAX)) ? VAR_MAX
                                                   : vsum[VARIANCE_BITS-1:0];
        end
        if (ctrl.gain_prep) begin
            den_next      = (VARIANCE_BITS+1)'(var_reg) + (VARIANCE_BITS+1)'(acc_sq);
            rem_next      = (VARIANCE_BITS+1)'(var_reg);
            den_zero_next = (var_reg == '0) && (acc_sq == '0);
            dec_next      = '0;
            k_next        = '0;
        end
        if (ctrl.gain_step) begin
            // Restoring division var / (var + acc^2), one gain bit per cycle.
            rem_next = qbit ? (VARIANCE_BITS+1)'(rem2 - (VARIANCE_BITS+2)'(den_reg))
                            : rem2[VARIANCE_BITS:0];
            k_next   = {k_reg[GAIN_FRAC_BITS-2:0], qbit};
        end
        if (ctrl.upd_step) begin
            // Gain bits go out LSB first and rotate back into place.
            dec_next = dsum[VARIANCE_BITS:1];
            k_next   = {k_reg[0], k_reg[GAIN_FRAC_BITS-1:1]};
        end
        if (ctrl.apply) begin
            var_next = var_reg - dec_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            var_reg <= '0;
            k_reg   <= '0;
        end else begin
            var_reg <= var_next;
            k_reg   <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        den_zero_reg <= den_zero_next;
        dec_reg      <= dec_next;
    end

    assign var_out = var_reg;
    assign gain    = k_reg;
    assign k_bit   = k_reg[0];

endmodule

### rtl/core/skf_coord_lane.sv
// One coordinate of the estimate: residual and bit-serial gain product with
// floor shift, then the update. Depends on skf_pkg.
module skf_coord_lane
    import skf_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  skf_ctrl_t                   ctrl,
    input  logic signed [EST_BITS-1:0]  meas_in,
    input  logic                        k_bit,
    output logic signed [EST_BITS-1:0]  est
);

    logic signed [EST_BITS-1:0] meas_reg;
    logic signed [EST_BITS-1:0] est_reg, est_next;
    logic signed [RES_BITS-1:0] res_reg, res_next;
    logic signed [RES_BITS-1:0] acc_reg, acc_next;
    logic signed [RES_BITS:0]   asum;
    logic signed [RES_BITS-1:0] esum;

    // Each step adds the residual for a set gain bit and halves, which
    // floors the product by the gain scale after the last bit.
    always_comb begin
        asum = (RES_BITS+1)'(acc_reg) + (k_bit ? (RES_BITS+1)'(res_reg) : '0);
        esum = RES_BITS'(est_reg) + acc_reg;
    end

    always_comb begin
        est_next = est_reg;
        res_next = res_reg;
        acc_next = acc_reg;
        if (ctrl.first_fix) begin
            est_next = meas_reg;
        end
        if (ctrl.gain_prep) begin
            res_next = RES_BITS'(meas_reg) - RES_BITS'(est_reg);
            acc_next = '0;
        end
        if (ctrl.upd_step) begin
            acc_next = asum[RES_BITS:1];
        end
        if (ctrl.apply) begin
            est_next = esum[EST_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg <= '0;
        end else begin
            est_reg <= est_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            meas_reg <= meas_in;
        end
        res_reg <= res_next;
        acc_reg <= acc_next;
    end

    assign est = est_reg;

endmodule

### rtl/core/scalar_kalman_position_filter_core.sv
// Scalar Kalman position filter: top level with sequencer, registers and output stage.
// A new fix is accepted only in idle, once the previous result is in the output register. Later fixes
// run the squares, the elapsed-time product, the 64-step divide by 1000 (which dominates), the gain
// division and the update; the first fix runs only the squares before its result is output.
// Reset clears the estimate, variance and initialized flag and loads min_accuracy_cm = 100
// and decay_cm_per_s = 300. Depends on skf_pkg and the skf_* units.
module scalar_kalman_position_filter_core
    import skf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [LAT_BITS-1:0]    s_meas_lat,
    input  logic signed [LNG_BITS-1:0]    s_meas_lng,
    input  logic signed [ALT_BITS-1:0]    s_meas_alt,
    input  logic [ACC_BITS-1:0]           s_meas_accuracy,
    input  logic [ELAPSED_BITS-1:0]       s_elapsed_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [LAT_BITS-1:0]    m_est_lat_out,
    output logic signed [LNG_BITS-1:0]    m_est_lng_out,
    output logic signed [ALT_BITS-1:0]    m_est_alt_out,
    output logic [VOUT_BITS-1:0]          m_variance_out,
    output logic [GAIN_OUT_BITS-1:0]      m_gain_out
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQUARE = 4'd1;
    localparam logic [3:0] ST_FIRST  = 4'd2;
    localparam logic [3:0] ST_MUL    = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_ADD    = 4'd5;
    localparam logic [3:0] ST_PREP   = 4'd6;
    localparam logic [3:0] ST_GAIN   = 4'd7;
    localparam logic [3:0] ST_UPD    = 4'd8;
    localparam logic [3:0] ST_APPLY  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    localparam int VEXT_BITS = (VARIANCE_BITS > VOUT_BITS) ? VARIANCE_BITS : VOUT_BITS;
    localparam logic [VOUT_BITS-1:0] VOUT_MAX = {VOUT_BITS{1'b1}};

    logic [3:0]                  state_reg, state_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic                        init_reg, init_next;
    logic [ACC_BITS-1:0]         min_acc_reg;
    logic [ACC_BITS-1:0]         decay_reg;
    logic                        in_accept;
    logic                        out_load;
    logic [ACC_BITS-1:0]         acc_clamped;
    skf_ctrl_t                   ctrl;

    logic [SQ_BITS-1:0]          acc_sq;
    logic [GROWTH_BITS-1:0]      growth;
    logic [VARIANCE_BITS-1:0]    var_value;
    logic [GAIN_FRAC_BITS-1:0]   gain;
    logic                        k_bit;
    logic signed [EST_BITS-1:0]  est_lat;
    logic signed [EST_BITS-1:0]  est_lng;
    logic signed [EST_BITS-1:0]  est_alt;

    logic [GAIN_FRAC_BITS+GAIN_OUT_BITS-1:0] gain_wide;
    logic [VEXT_BITS-1:0]        var_ext;
    logic [VOUT_BITS-1:0]        var_sat;

    logic                        m_valid_reg, m_valid_next;
    logic signed [LAT_BITS-1:0]  lat_out_reg;
    logic signed [LNG_BITS-1:0]  lng_out_reg;
    logic signed [ALT_BITS-1:0]  alt_out_reg;
    logic [VOUT_BITS-1:0]        var_out_reg;
    logic [GAIN_OUT_BITS-1:0]    gain_out_reg;

    // Configuration registers; the user must write them only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_acc_reg <= MIN_ACCURACY_RESET;
            decay_reg   <= DECAY_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_ACCURACY: min_acc_reg <= cfg_data;
                REG_DECAY:        decay_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input transaction and accuracy clamp.
    assign s_ready     = (state_reg == ST_IDLE);
    assign in_accept   = s_valid && s_ready;
    assign acc_clamped = (s_meas_accuracy < min_acc_reg) ? min_acc_reg : s_meas_accuracy;

    // Sequencer: one strobe per serial step, counted by cnt_reg.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        init_next  = init_reg;
        ctrl       = '0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    ctrl.load  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                ctrl.sq_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(ACC_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = init_reg ? ST_MUL : ST_FIRST;
                end
            end
            ST_FIRST: begin
                ctrl.first_fix = 1'b1;
                init_next      = 1'b1;
                state_next     = ST_OUT;
            end
            ST_MUL: begin
                ctrl.mul_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(ELAPSED_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                ctrl.div_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(PROD_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                ctrl.var_add = 1'b1;
                state_next   = ST_PREP;
            end
            ST_PREP: begin
                ctrl.gain_prep = 1'b1;
                cnt_next       = '0;
                state_next     = ST_GAIN;
            end
            ST_GAIN: begin
                ctrl.gain_step = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(GAIN_FRAC_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                ctrl.upd_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(GAIN_FRAC_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                ctrl.apply = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            init_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            init_reg  <= init_next;
        end
    end

    // Serial arithmetic units.
    skf_growth_unit u_growth (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .acc_in     (acc_clamped),
        .decay      (decay_reg),
        .elapsed_in (s_elapsed_ms),
        .acc_sq     (acc_sq),
        .growth     (growth)
    );

    skf_var_gain u_var_gain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .acc_sq  (acc_sq),
        .growth  (growth),
        .var_out (var_value),
        .gain    (gain),
        .k_bit   (k_bit)
    );

    skf_coord_lane u_lane_lat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .meas_in (EST_BITS'(s_meas_lat)),
        .k_bit   (k_bit),
        .est     (est_lat)
    );

    skf_coord_lane u_lane_lng (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .meas_in (EST_BITS'(s_meas_lng)),
        .k_bit   (k_bit),
        .est     (est_lng)
    );

    skf_coord_lane u_lane_alt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .meas_in (EST_BITS'(s_meas_alt)),
        .k_bit   (k_bit),
        .est     (est_alt)
    );

    // Rescale the gain to Q0.16 and saturate the variance to the output width.
    always_comb begin
        gain_wide = {gain, {GAIN_OUT_BITS{1'b0}}} >> GAIN_FRAC_BITS;
        var_ext   = VEXT_BITS'(var_value);
        var_sat   = (var_ext > VEXT_BITS'(VOUT_MAX)) ? VOUT_MAX : var_ext[VOUT_BITS-1:0];
    end

    // Output register: holds one finished result until the transaction completes.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            lat_out_reg  <= est_lat[LAT_BITS-1:0];
            lng_out_reg  <= est_lng[LNG_BITS-1:0];
            alt_out_reg  <= est_alt[ALT_BITS-1:0];
            var_out_reg  <= var_sat;
            gain_out_reg <= gain_wide[GAIN_OUT_BITS-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_est_lat_out  = lat_out_reg;
    assign m_est_lng_out  = lng_out_reg;
    assign m_est_alt_out  = alt_out_reg;
    assign m_variance_out = var_out_reg;
    assign m_gain_out     = gain_out_reg;

endmodule
